[hdl/bmd_pkg.sv]
// ----------------------------------------------------------------------------
// bmd_pkg
// shared codes and address constants for the bank-switched address decoder
// ----------------------------------------------------------------------------
`default_nettype none

package bmd_pkg;

  // request kinds
  localparam logic [1:0] REQ_READ     = 2'd0;
  localparam logic [1:0] REQ_WRITE    = 2'd1;
  localparam logic [1:0] REQ_SELECT   = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;   // decodes to nothing

  // decode targets
  localparam logic [3:0] TGT_RAM    = 4'd0;
  localparam logic [3:0] TGT_LOROM  = 4'd1;   // base of low rom banks 0-3
  localparam logic [3:0] TGT_HIROM  = 4'd5;   // base of high rom banks 0-3
  localparam logic [3:0] TGT_SERIAL = 4'd9;
  localparam logic [3:0] TGT_PIO1   = 4'd10;
  localparam logic [3:0] TGT_PIO2   = 4'd11;
  localparam logic [3:0] TGT_VIDEO  = 4'd12;
  localparam logic [3:0] TGT_PORT   = 4'd13;
  localparam logic [3:0] TGT_NONE   = 4'd14;

  // pages and sub-ranges inside the i/o pages
  localparam logic [7:0] PAGE_IO       = 8'hfd;
  localparam logic [7:0] PAGE_VIDEO    = 8'hff;
  localparam logic [7:0] PAGE_MAIN_HI  = 8'hfc;
  localparam logic [3:0] IO_SLOT_SER   = 4'h0;
  localparam logic [3:0] IO_SLOT_PIO1  = 4'h1;
  localparam logic [3:0] IO_SLOT_PIO2  = 4'h3;
  localparam logic [3:0] IO_SLOT_BANK  = 4'hd;
  localparam logic [6:0] VIDEO_TOP_PAIR = 7'h1f;   // ff3e and ff3f

  localparam logic [7:0] PORT_READ_MASK = 8'h3f;
  localparam int unsigned TAPE_BIT  = 4;
  localparam int unsigned MOTOR_BIT = 3;

  localparam logic [4:0] BANK_CONFIG_RESET = 5'd1;

endpackage

`default_nettype wire

[hdl/banked_memory_decoder_with_cpu_port_core.sv]
// ----------------------------------------------------------------------------
// banked_memory_decoder_with_cpu_port_core
// bank-switched cpu address decoder with built-in cpu i/o port
// ----------------------------------------------------------------------------
// Each input item is one cpu bus access (read, write, or a ram/rom select
// event). It is decoded combinationally against the 5-bit bank
// configuration and the built-in cpu port, and one result item comes out of
// the output register on the next clock. An item
// can be accepted every clock; s_axis_tready only drops when the output
// register holds an item the sink has not yet taken. The decode is a few
// compares on the address page plus the port read mux, all between the
// state registers and the result register. Writes to fdd0-fddf latch the
// rom bank bits; a select request sets the ram/rom bit from rom_enable;
// writes to addresses 0 and 1 update the port direction and data, the
// output latch and the tape motor. serial_lines_out and motor_on in each
// result reflect the port state after that access.
// ----------------------------------------------------------------------------
`default_nettype none

module banked_memory_decoder_with_cpu_port_core (
  input  wire         clk,
  input  wire         rst,
  // access in
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] address, [23:16] write_data, [24] rom_enable, [32:25] serial_in,
  // [33] tape_in, [39:34] zero
  input  wire  [39:0] s_axis_tdata,
  // [1:0] req_type
  input  wire  [1:0]  s_axis_tuser,
  // decode out
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [15:0] offset, [16] write_en, [24:17] port_read_data,
  // [32:25] serial_lines_out, [33] motor_on, [39:34] zero
  output logic [39:0] m_axis_tdata,
  // [3:0] target
  output logic [3:0]  m_axis_tuser
);

  import bmd_pkg::*;

  // input field split
  logic [1:0]  req_type;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic        rom_enable;
  logic [7:0]  serial_in;
  logic        tape_in;
  logic [7:0]  page;
  logic        in_accept;
  logic        is_wr;

  assign req_type   = s_axis_tuser;
  assign address    = s_axis_tdata[15:0];
  assign write_data = s_axis_tdata[23:16];
  assign rom_enable = s_axis_tdata[24];
  assign serial_in  = s_axis_tdata[32:25];
  assign tape_in    = s_axis_tdata[33];
  assign page       = address[15:8];
  assign is_wr      = (req_type == REQ_WRITE);

  // output register frees up when empty or being taken
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // state
  logic [4:0] bank_config, bank_config_next;
  logic [7:0] port_dir, port_dir_next;
  logic [7:0] port_data, port_data_next;
  logic [7:0] port_latch, port_latch_next;
  logic       motor_state, motor_state_next;

  // decode results
  logic [3:0]  target;
  logic [15:0] offset;
  logic        write_en;
  logic [7:0]  port_read_data;
  logic [7:0]  port_pin_read;

  // result register
  logic [3:0]  res_target;
  logic [15:0] res_offset;
  logic        res_write_en;
  logic [7:0]  res_port_read;
  logic [7:0]  res_serial_out;
  logic        res_motor;

  // pin level seen on a read of port address 1
  always_comb begin
    port_pin_read = ((port_data | ~port_dir) & (port_latch | PORT_READ_MASK)) | serial_in;
    if (tape_in) begin
      port_pin_read[TAPE_BIT] = 1'b0;
    end
  end

  always_comb begin
    target           = TGT_NONE;
    offset           = 16'd0;
    write_en         = 1'b0;
    port_read_data   = 8'd0;
    bank_config_next = bank_config;
    port_dir_next    = port_dir;
    port_data_next   = port_data;
    port_latch_next  = port_latch;
    motor_state_next = motor_state;

    case (req_type)
      REQ_SELECT: begin
        bank_config_next[0] = rom_enable;
      end
      REQ_READ, REQ_WRITE: begin
        if (address[15:1] == 15'd0) begin
          // cpu port at 0000/0001
          target = TGT_PORT;
          offset = {15'd0, address[0]};
          if (is_wr) begin
            if (address[0]) begin
              port_data_next = write_data;
            end else begin
              port_dir_next = write_data;
            end
            port_latch_next  = (port_latch & ~port_dir_next) |
                               (port_data_next & port_dir_next);
            motor_state_next = !(port_dir_next[MOTOR_BIT] && port_data_next[MOTOR_BIT]);
            write_en = 1'b1;
          end else if (address[0]) begin
            port_read_data = port_pin_read;
          end else begin
            port_read_data = port_dir;
          end
        end else if (page == PAGE_IO) begin
          // i/o chips in 16-byte slots; bank latch only on writes
          if (address[7:4] == IO_SLOT_SER) begin
            target = TGT_SERIAL;
            offset = {12'd0, address[3:0]};
          end else if (address[7:4] == IO_SLOT_PIO1) begin
            target = TGT_PIO1;
            offset = {12'd0, address[3:0]};
          end else if (address[7:4] == IO_SLOT_PIO2) begin
            target = TGT_PIO2;
            offset = {12'd0, address[3:0]};
          end else if (is_wr && address[7:4] == IO_SLOT_BANK) begin
            bank_config_next[4:1] = address[3:0];
          end
          write_en = is_wr && (target != TGT_NONE);
        end else if (page == PAGE_VIDEO &&
                     (address[7:5] == 3'd0 || address[7:1] == VIDEO_TOP_PAIR)) begin
          target   = TGT_VIDEO;
          offset   = {8'd0, address[7:0]};
          write_en = is_wr;
        end else if (is_wr) begin
          // rom area writes land in ram underneath
          target   = TGT_RAM;
          offset   = address;
          write_en = 1'b1;
        end else if (bank_config[0] && address[15:14] == 2'b10) begin
          target = TGT_LOROM + {2'd0, bank_config[2:1]};
          offset = {2'd0, address[13:0]};
        end else if (bank_config[0] && address[15:14] == 2'b11) begin
          // page fc always maps the main high rom
          if (page == PAGE_MAIN_HI) begin
            target = TGT_HIROM;
          end else begin
            target = TGT_HIROM + {2'd0, bank_config[4:3]};
          end
          offset = {2'd0, address[13:0]};
        end else begin
          target = TGT_RAM;
          offset = address;
        end
      end
      default: begin
        // unused request code: no decode, no state change
      end
    endcase
  end

  // state registers, updated only on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_config <= BANK_CONFIG_RESET;
      port_dir    <= 8'd0;
      port_data   <= 8'd0;
      port_latch  <= 8'd0;
      motor_state <= 1'b0;
    end else if (in_accept) begin
      bank_config <= bank_config_next;
      port_dir    <= port_dir_next;
      port_data   <= port_data_next;
      port_latch  <= port_latch_next;
      motor_state <= motor_state_next;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_target     <= target;
      res_offset     <= offset;
      res_write_en   <= write_en;
      res_port_read  <= port_read_data;
      res_serial_out <= ~port_latch_next;
      res_motor      <= motor_state_next;
    end
  end

  assign m_axis_tuser = res_target;
  assign m_axis_tdata = {6'd0, res_motor, res_serial_out, res_port_read,
                         res_write_en, res_offset};

  // an accepted item always shows up in the output register next cycle
  a_accept_to_valid: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> m_axis_tvalid)
    else $error("accepted item did not reach output register");

  // a bank latch write loads bits 4:1 and keeps the rom select bit
  a_bank_latch: assert property (@(posedge clk) disable iff (rst)
    (in_accept && is_wr && page == PAGE_IO && address[7:4] == IO_SLOT_BANK)
    |=> (bank_config[4:1] == $past(address[3:0]) &&
         bank_config[0] == $past(bank_config[0])))
    else $error("bank latch write not applied");

  // nothing is written when the decode lands nowhere
  a_none_no_write: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res_target == TGT_NONE) |-> !res_write_en)
    else $error("write enable on target none");

  // port read data only comes from the cpu port
  a_port_read_src: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res_target != TGT_PORT) |-> (res_port_read == 8'd0))
    else $error("port read data outside port target");

  // serial lines always mirror the inverted latch of the last accepted item
  a_serial_mirror: assert property (@(posedge clk) disable iff (rst)
    (in_accept && $past(in_accept)) |-> (res_serial_out == ~port_latch))
    else $error("serial lines out of step with port latch");

endmodule

`default_nettype wire

[test/bmd_decode_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmd_decode_checker
// watches both streams of the decoder, predicts each decode from its own copy
// of the bank and cpu port state, and compares results in order
// ----------------------------------------------------------------------------

module bmd_decode_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  input  wire  [39:0] s_axis_tdata,
  input  wire  [1:0]  s_axis_tuser,
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire  [39:0] m_axis_tdata,
  input  wire  [3:0]  m_axis_tuser,
  output int          fail_count,
  output int          pending_count
);

  import bmd_pkg::*;

  typedef struct packed {
    logic [3:0]  target;
    logic [15:0] offset;
    logic        write_en;
    logic [7:0]  port_rd;
    logic [7:0]  serial_out;
    logic        motor_on;
  } decode_t;

  // shadow of the decoder state
  logic [4:0] bank_cfg;
  logic [7:0] pdir, pdat, platch;
  logic       motor;

  decode_t expected_decodes[$];

  function automatic decode_t decode_access(input logic [1:0] req, input logic [15:0] addr,
                                            input logic [7:0] wd, input logic romen,
                                            input logic [7:0] ser, input logic tape);
    decode_t    r;
    logic       wr;
    logic       rom_sel;
    logic [7:0] page;
    r = '0;
    r.target = TGT_NONE;
    wr = (req == REQ_WRITE);
    rom_sel = bank_cfg[0];
    page = addr[15:8];
    if (req == REQ_SELECT) begin
      bank_cfg[0] = romen;
    end else if (req == REQ_READ || wr) begin
      if (addr <= 16'd1) begin
        r.target = TGT_PORT;
        r.offset = addr;
        if (wr) begin
          if (addr == 16'd0) pdir = wd;
          else pdat = wd;
          platch = (platch & ~pdir) | (pdat & pdir);
          motor = ((pdir & pdat) >> MOTOR_BIT) & 8'd1 ? 1'b0 : 1'b1;
          r.write_en = 1'b1;
        end else if (addr == 16'd0) begin
          r.port_rd = pdir;
        end else begin
          r.port_rd = ((pdat | ~pdir) & (platch | PORT_READ_MASK)) | ser;
          if (tape) r.port_rd[TAPE_BIT] = 1'b0;
        end
      end else if (page == PAGE_IO) begin
        if (addr <= 16'hfd0f) begin
          r.target = TGT_SERIAL;
          r.offset = addr - 16'hfd00;
        end else if (addr <= 16'hfd1f) begin
          r.target = TGT_PIO1;
          r.offset = addr - 16'hfd10;
        end else if (addr >= 16'hfd30 && addr <= 16'hfd3f) begin
          r.target = TGT_PIO2;
          r.offset = addr - 16'hfd30;
        end else if (wr && addr >= 16'hfdd0 && addr <= 16'hfddf) begin
          bank_cfg[4:1] = addr[3:0];
        end
        r.write_en = wr && (r.target != TGT_NONE);
      end else if (page == PAGE_VIDEO &&
                   (addr < 16'hff20 || addr == 16'hff3e || addr == 16'hff3f)) begin
        r.target = TGT_VIDEO;
        r.offset = addr - 16'hff00;
        r.write_en = wr;
      end else if (wr) begin
        r.target = TGT_RAM;
        r.offset = addr;
        r.write_en = 1'b1;
      end else if (rom_sel && page >= 8'h80 && page <= 8'hbf) begin
        r.target = TGT_LOROM + {2'b00, bank_cfg[2:1]};
        r.offset = addr & 16'h3fff;
      end else if (rom_sel && page >= 8'hc0) begin
        r.target = (page == PAGE_MAIN_HI) ? TGT_HIROM : TGT_HIROM + {2'b00, bank_cfg[4:3]};
        r.offset = addr & 16'h3fff;
      end else begin
        r.target = TGT_RAM;
        r.offset = addr;
      end
    end
    r.serial_out = ~platch;
    r.motor_on = motor;
    return r;
  endfunction

  always @(posedge clk) begin
    decode_t exp_d;
    decode_t got_d;
    logic    bad;
    if (rst) begin
      bank_cfg = BANK_CONFIG_RESET;
      pdir = '0;
      pdat = '0;
      platch = '0;
      motor = 1'b0;
      expected_decodes.delete();
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_d = '{target: m_axis_tuser, offset: m_axis_tdata[15:0],
                  write_en: m_axis_tdata[16], port_rd: m_axis_tdata[24:17],
                  serial_out: m_axis_tdata[32:25], motor_on: m_axis_tdata[33]};
        if (expected_decodes.size() == 0) begin
          $display("%0t: unexpected result item %h", $time, got_d);
          fail_count <= fail_count + 1;
        end else begin
          exp_d = expected_decodes.pop_front();
          bad = 1'b0;
          if (got_d.target != exp_d.target) begin
            $display("%0t: target expected %0d actual %0d", $time, exp_d.target, got_d.target);
            bad = 1'b1;
          end
          if (got_d.offset != exp_d.offset) begin
            $display("%0t: offset expected %h actual %h", $time, exp_d.offset, got_d.offset);
            bad = 1'b1;
          end
          if (got_d.write_en != exp_d.write_en) begin
            $display("%0t: write_en expected %b actual %b", $time,
                     exp_d.write_en, got_d.write_en);
            bad = 1'b1;
          end
          if (got_d.port_rd != exp_d.port_rd) begin
            $display("%0t: port_read_data expected %h actual %h", $time,
                     exp_d.port_rd, got_d.port_rd);
            bad = 1'b1;
          end
          if (got_d.serial_out != exp_d.serial_out) begin
            $display("%0t: serial_lines_out expected %h actual %h", $time,
                     exp_d.serial_out, got_d.serial_out);
            bad = 1'b1;
          end
          if (got_d.motor_on != exp_d.motor_on) begin
            $display("%0t: motor_on expected %b actual %b", $time,
                     exp_d.motor_on, got_d.motor_on);
            bad = 1'b1;
          end
          if (bad) fail_count <= fail_count + 1;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_decodes.push_back(decode_access(s_axis_tuser, s_axis_tdata[15:0],
                                                 s_axis_tdata[23:16], s_axis_tdata[24],
                                                 s_axis_tdata[32:25], s_axis_tdata[33]));
      end
      pending_count <= expected_decodes.size();
    end
  end

endmodule

[test/tb_banked_memory_decoder_with_cpu_port_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_banked_memory_decoder_with_cpu_port_core
// drives cpu bus accesses into the decoder with random gaps on both sides;
// a checker beside the block predicts and compares every decode
// ----------------------------------------------------------------------------

module tb_banked_memory_decoder_with_cpu_port_core;
  import bmd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 750;
  localparam int QUIET_ITEMS  = 150;   // tail of the run with no idling

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;    // [15:0] address, [23:16] write_data, [24] rom_enable,
                                // [32:25] serial_in, [33] tape_in, [39:34] zero
  logic [1:0]  s_axis_tuser;    // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;    // [15:0] offset, [16] write_en, [24:17] port_read_data,
                                // [32:25] serial_lines_out, [33] motor_on, [39:34] zero
  logic [3:0]  m_axis_tuser;    // [3:0] target

  int fail_count;
  int pending_count;
  int cycle_count;
  bit idling;                   // random gaps and stalls allowed

  banked_memory_decoder_with_cpu_port_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  bmd_decode_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result sink: tready drops in random bursts while idling is on
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idling && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 9);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one access item, with an optional gap in front of it
  task automatic send_access(input logic [1:0] req, input logic [15:0] addr,
                             input logic [7:0] wd, input logic romen,
                             input logic [7:0] ser, input logic tape);
    if (idling && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {6'b0, tape, ser, romen, wd, addr};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // address mix weighted toward the decode boundaries
  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 11))
      0:       return 16'($urandom_range(0, 1));                  // cpu port
      1:       return {8'h00, 8'($urandom_range(0, 255))};        // zero page
      2:       return {PAGE_IO, 8'($urandom_range(0, 255))};      // i/o page
      3:       return 16'hfdd0 | 16'($urandom_range(0, 15));      // bank latch
      4:       return 16'hff00 | 16'($urandom_range(0, 63));      // video edges
      5:       return {PAGE_VIDEO, 8'($urandom_range(0, 255))};
      6:       return {PAGE_MAIN_HI, 8'($urandom_range(0, 255))};
      7:       return 16'($urandom_range(16'h8000, 16'hbfff));    // low rom area
      8:       return 16'($urandom_range(16'hc000, 16'hffff));    // high rom area
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int         n;
    logic [1:0] req;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_READ;
    idling = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // port reads from reset state, serial and tape merge
    send_access(REQ_READ,  16'h0000, 8'h00, 1'b0, 8'h00, 1'b0);
    send_access(REQ_READ,  16'h0001, 8'h00, 1'b0, 8'h00, 1'b0);
    send_access(REQ_READ,  16'h0001, 8'h00, 1'b0, 8'hff, 1'b1);
    // rom reads with base banks, main high rom page, page ff past the video chip
    send_access(REQ_READ,  16'h8000, 8'h00, 1'b0, 8'h00, 1'b0);
    send_access(REQ_READ,  16'hc000, 8'h00, 1'b0, 8'h00, 1'b0);
    send_access(REQ_READ,  16'hfc00, 8'h00, 1'b0, 8'h00, 1'b0);
    send_access(REQ_READ,  16'hffff, 8'h00, 1'b0, 8'h00, 1'b0);
    send_access(REQ_READ,  16'h7fff, 8'h00, 1'b0, 8'h00, 1'b0);
    // bank latch write, then the switched banks
    send_access(REQ_WRITE, 16'hfddf, 8'hff, 1'b0, 8'h00, 1'b0);
    send_access(REQ_READ,  16'hbfff, 8'h00, 1'b0, 8'h00, 1'b0);
    send_access(REQ_READ,  16'hfcff, 8'h00, 1'b0, 8'h00, 1'b0);
    send_access(REQ_READ,  16'hfe00, 8'h00, 1'b0, 8'h00, 1'b0);
    // port direction and data, motor off then on
    send_access(REQ_WRITE, 16'h0000, 8'hff, 1'b0, 8'h00, 1'b0);
    send_access(REQ_WRITE, 16'h0001, 8'h08, 1'b0, 8'h00, 1'b0);
    send_access(REQ_READ,  16'h0001, 8'h00, 1'b0, 8'h00, 1'b1);
    send_access(REQ_WRITE, 16'h0001, 8'h00, 1'b0, 8'h00, 1'b0);
    // i/o chips, unused slots and the video chip
    send_access(REQ_READ,  16'hfd00, 8'h00, 1'b0, 8'h00, 1'b0);
    send_access(REQ_WRITE, 16'hfd1f, 8'h5a, 1'b0, 8'h00, 1'b0);
    send_access(REQ_READ,  16'hfd25, 8'h00, 1'b0, 8'h00, 1'b0);
    send_access(REQ_WRITE, 16'hfd3f, 8'ha5, 1'b0, 8'h00, 1'b0);
    send_access(REQ_WRITE, 16'hfdff, 8'h00, 1'b0, 8'h00, 1'b0);
    send_access(REQ_READ,  16'hff1f, 8'h00, 1'b0, 8'h00, 1'b0);
    send_access(REQ_WRITE, 16'hff3e, 8'h00, 1'b0, 8'h00, 1'b0);
    send_access(REQ_WRITE, 16'hff20, 8'h00, 1'b0, 8'h00, 1'b0);
    // ram selected, a read of the rom area, the unused request kind, rom selected again
    send_access(REQ_SELECT, 16'h0000, 8'h00, 1'b0, 8'h00, 1'b0);
    send_access(REQ_READ,  16'h8000, 8'h00, 1'b0, 8'h00, 1'b0);
    send_access(REQ_RESERVED, 16'h0001, 8'hff, 1'b1, 8'hff, 1'b1);
    send_access(REQ_SELECT, 16'hffff, 8'hff, 1'b1, 8'h00, 1'b0);

    // random accesses, quiet tail with no gaps or stalls
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) idling = 1'b0;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8:          req = REQ_READ;
        9, 10, 11, 12, 13, 14, 15, 16:      req = REQ_WRITE;
        17, 18:                             req = REQ_SELECT;
        default:                            req = REQ_RESERVED;
      endcase
      send_access(req, pick_address(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    s_axis_tvalid <= 1'b0;

    // drain, then wait for any stray result
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
